FILE: rtl/mbo_pkg.sv
// Shared types and constants for the multiply blend with opacity block.
`default_nettype none

package mbo_pkg;

    localparam int CH_N      = 3;             // blue, green, red
    localparam int C_W       = 16;            // min alpha times opacity
    localparam int DEN_W     = 24;            // ratio denominator
    localparam int DIV_STEPS = 17;            // one quotient bit per stage
    localparam int Q_W       = DIV_STEPS;     // ratio, Q1.16 up to 1.0
    localparam int NUM_W     = DEN_W + 16;    // ratio numerator
    localparam int PROD_W    = 32;            // channel numerator

    localparam logic [7:0]        OPACITY_RESET = 8'd255;
    localparam logic [C_W-1:0]    ALPHA_SQ      = 16'd65025;     // 255 * 255
    localparam logic [Q_W-1:0]    ONE_Q16       = 17'h10000;
    localparam logic [DEN_W-1:0]  MIX_FULL      = 24'd16711680;  // 255 * 65536
    localparam logic [PROD_W-1:0] MIX_HALF      = 32'd8355840;   // MIX_FULL / 2

    typedef struct packed {
        logic [7:0] base_blue;
        logic [7:0] base_green;
        logic [7:0] base_red;
        logic [7:0] base_alpha;
        logic [7:0] top_blue;
        logic [7:0] top_green;
        logic [7:0] top_red;
        logic [7:0] top_alpha;
    } mbo_in_t;

    typedef struct packed {
        logic [7:0] out_blue;
        logic [7:0] out_green;
        logic [7:0] out_red;
    } mbo_out_t;

    // Index 0 is blue, 1 green, 2 red.
    typedef logic [CH_N-1:0][7:0] mbo_pix_t;

    // Color data that rides along with the ratio computation.
    typedef struct packed {
        mbo_pix_t base;
        mbo_pix_t top;
        logic     zero;     // effective alpha is zero: pass base through
    } mbo_side_t;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } mbo_frac_t;

endpackage

`default_nettype wire

FILE: rtl/multiply_blend_with_opacity_core.sv
// Top level of the multiply blend with opacity pipeline.
`default_nettype none

// Blends one top BGRA pixel over one base BGRA pixel in multiply mode,
// weighted by the opacity register, and returns the blended BGR pixel.
// Feed alpha as 255 for three-channel sources. The pipeline takes one word
// per clock while the output is not stalled and passes each word through
// 4 front stages (effective alpha, new alpha, rounded numerator), 17
// divider stages that produce the Q1.16 mixing ratio one bit per stage,
// and 3 mix stages ending in the output
// register. Every stage has its own valid bit and advances whenever the
// stage after it is empty or moving, so bubbles close up and new words
// keep entering while a finished result waits at m_data. Results come out
// in input order. A word whose effective alpha is zero returns the base
// color unchanged. Write opacity (reset 255) only while no word is in
// flight.

module multiply_blend_with_opacity_core
    import mbo_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    // configuration
    input  wire logic     cfg_wr_en,
    input  wire logic [7:0] cfg_wr_data,
    // pixel pair in
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire mbo_in_t  s_data,
    // blended pixel out
    output logic          m_valid,
    input  wire logic     m_ready,
    output mbo_out_t      m_data
);

    logic [7:0] opacity_reg;

    // Links between the three pipeline sections.
    logic      front_valid, front_ready;
    mbo_frac_t front_frac;
    mbo_side_t front_side;
    logic      div_valid, div_ready;
    logic [Q_W-1:0] div_q;
    mbo_side_t div_side;

    // Hold the opacity; take a new value on every write enable.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            opacity_reg <= OPACITY_RESET;
        end else if (cfg_wr_en) begin
            opacity_reg <= cfg_wr_data;
        end
    end

    // Effective alpha, new alpha and the rounded ratio numerator.
    mbo_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .opacity   (opacity_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_frac  (front_frac),
        .out_side  (front_side)
    );

    // Ratio = effective alpha over new alpha, one quotient bit per stage.
    mbo_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_frac   (front_frac),
        .in_side   (front_side),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_q     (div_q),
        .out_side  (div_side)
    );

    // Mix product and base per channel; round and drive the output register.
    mbo_mix u_mix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (div_valid),
        .in_ready  (div_ready),
        .in_q      (div_q),
        .in_side   (div_side),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

endmodule

`default_nettype wire

FILE: rtl/mbo_front.sv
// Front end: effective alpha, new alpha and the rounded ratio numerator.
`default_nettype none

module mbo_front
    import mbo_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic [7:0] opacity,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire mbo_in_t   in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output mbo_frac_t      out_frac,
    output mbo_side_t      out_side
);

    localparam int STAGES = 4;

    logic vld_reg [STAGES];
    logic adv     [STAGES];

    // stage 1: min alpha times opacity
    logic [7:0]       a1_s1_reg,   a1_s1_next;
    logic [C_W-1:0]   c_s1_reg,    c_s1_next;
    mbo_side_t        side_s1_reg, side_s1_next;
    // stage 2: partial products of the new alpha
    logic [DEN_W-1:0] p1_s2_reg,   p1_s2_next;
    logic [DEN_W-1:0] p2_s2_reg,   p2_s2_next;
    logic [DEN_W-1:0] c255_s2_reg, c255_s2_next;
    mbo_side_t        side_s2_reg;
    // stage 3: new alpha
    logic [DEN_W-1:0] n_s3_reg,    n_s3_next;
    logic [DEN_W-1:0] c255_s3_reg;
    mbo_side_t        side_s3_reg;
    // stage 4: numerator with half the divisor for rounding
    mbo_frac_t        frac_s4_reg, frac_s4_next;
    mbo_side_t        side_s4_reg;

    logic [7:0] min_alpha;

    assign adv[STAGES-1] = !vld_reg[STAGES-1] || out_ready;
    for (genvar k = 0; k < STAGES - 1; k++) begin : g_adv
        assign adv[k] = !vld_reg[k] || adv[k+1];
    end
    assign in_ready = adv[0];

    always_comb begin
        min_alpha = (in_data.base_alpha < in_data.top_alpha) ? in_data.base_alpha
                                                             : in_data.top_alpha;
        a1_s1_next = in_data.base_alpha;
        c_s1_next  = C_W'(min_alpha) * C_W'(opacity);
        side_s1_next.base = {in_data.base_red, in_data.base_green, in_data.base_blue};
        side_s1_next.top  = {in_data.top_red, in_data.top_green, in_data.top_blue};
        side_s1_next.zero = (min_alpha == 8'd0) || (opacity == 8'd0);

        p1_s2_next   = DEN_W'(a1_s1_reg) * DEN_W'(ALPHA_SQ);
        p2_s2_next   = DEN_W'(8'd255 - a1_s1_reg) * DEN_W'(c_s1_reg);
        c255_s2_next = (DEN_W'(c_s1_reg) << 8) - DEN_W'(c_s1_reg);

        n_s3_next = p1_s2_reg + p2_s2_reg;

        frac_s4_next.num = {c255_s3_reg, 16'd0} + NUM_W'(n_s3_reg >> 1);
        frac_s4_next.den = n_s3_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < STAGES; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else begin
            if (adv[0]) vld_reg[0] <= in_valid;
            for (int k = 1; k < STAGES; k++) begin
                if (adv[k]) vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            a1_s1_reg   <= a1_s1_next;
            c_s1_reg    <= c_s1_next;
            side_s1_reg <= side_s1_next;
        end
        if (adv[1]) begin
            p1_s2_reg   <= p1_s2_next;
            p2_s2_reg   <= p2_s2_next;
            c255_s2_reg <= c255_s2_next;
            side_s2_reg <= side_s1_reg;
        end
        if (adv[2]) begin
            n_s3_reg    <= n_s3_next;
            c255_s3_reg <= c255_s2_reg;
            side_s3_reg <= side_s2_reg;
        end
        if (adv[3]) begin
            frac_s4_reg <= frac_s4_next;
            side_s4_reg <= side_s3_reg;
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign out_frac  = frac_s4_reg;
    assign out_side  = side_s4_reg;

    // New alpha bounds 255 * C, so the ratio never exceeds 1.0 in Q1.16.
    a_den_bounds_num: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[2] && !side_s3_reg.zero |-> n_s3_reg >= c255_s3_reg && n_s3_reg != '0)
        else $error("new alpha below 255 times effective alpha");

endmodule

`default_nettype wire

FILE: rtl/mbo_div.sv
// Pipelined restoring divider: one ratio bit per stage.
`default_nettype none

module mbo_div
    import mbo_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire mbo_frac_t in_frac,
    input  wire mbo_side_t in_side,
    output logic           out_valid,
    input  wire logic      out_ready,
    output logic [Q_W-1:0] out_q,
    output mbo_side_t      out_side
);

    logic             vld_reg  [DIV_STEPS];
    logic             adv      [DIV_STEPS];
    logic [DEN_W-1:0] rem_reg  [DIV_STEPS];
    logic [DEN_W-1:0] den_reg  [DIV_STEPS];
    logic [Q_W-1:0]   q_reg    [DIV_STEPS];
    logic [Q_W-1:0]   lo_reg   [DIV_STEPS];
    mbo_side_t        side_reg [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic             vld_in, adv_nxt, ge;
        logic [DEN_W-1:0] rem_in, den_in, rem_next;
        logic [Q_W-1:0]   q_in, lo_in, q_next, lo_next;
        mbo_side_t        side_in;
        logic [DEN_W:0]   trial, diff;

        if (k == 0) begin : g_first
            // Top bits start the remainder; they stay below the divisor.
            assign vld_in  = in_valid;
            assign rem_in  = DEN_W'(in_frac.num[NUM_W-1:Q_W]);
            assign lo_in   = in_frac.num[Q_W-1:0];
            assign q_in    = '0;
            assign den_in  = in_frac.den;
            assign side_in = in_side;
        end else begin : g_next
            assign vld_in  = vld_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign lo_in   = lo_reg[k-1];
            assign q_in    = q_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        if (k == DIV_STEPS - 1) begin : g_last
            assign adv_nxt = out_ready;
        end else begin : g_mid
            assign adv_nxt = adv[k+1];
        end

        assign adv[k]   = !vld_reg[k] || adv_nxt;
        assign trial    = {rem_in, lo_in[Q_W-1]};
        assign ge       = trial >= {1'b0, den_in};
        assign diff     = trial - {1'b0, den_in};
        assign rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        assign q_next   = {q_in[Q_W-2:0], ge};
        assign lo_next  = {lo_in[Q_W-2:0], 1'b0};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (adv[k]) begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv[k]) begin
                rem_reg[k]  <= rem_next;
                den_reg[k]  <= den_in;
                q_reg[k]    <= q_next;
                lo_reg[k]   <= lo_next;
                side_reg[k] <= side_in;
            end
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[DIV_STEPS-1];
    assign out_q     = q_reg[DIV_STEPS-1];
    assign out_side  = side_reg[DIV_STEPS-1];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_chk
        a_rem_below_den: assert property (@(posedge aclk) disable iff (!aresetn)
            vld_reg[k] && !side_reg[k].zero |-> rem_reg[k] < den_reg[k])
            else $error("divider remainder not below divisor");
    end

    a_ratio_max: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && !out_side.zero |-> out_q <= ONE_Q16)
        else $error("ratio above one");

endmodule

`default_nettype wire

FILE: rtl/mbo_mix.sv
// Channel mix: product and base weighted by the ratio, rounded to bytes.
`default_nettype none

module mbo_mix
    import mbo_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [Q_W-1:0] in_q,
    input  wire mbo_side_t  in_side,
    output logic            out_valid,
    input  wire logic       out_ready,
    output mbo_out_t        out_data
);

    localparam int STAGES = 3;

    logic vld_reg [STAGES];
    logic adv     [STAGES];

    logic [Q_W-1:0]   r_eff;
    logic [DEN_W-1:0] prod_s1_reg [CH_N];
    logic [DEN_W-1:0] prod_s1_next [CH_N];
    mbo_side_t        side_s1_reg;
    logic [PROD_W-1:0] num_s2_reg  [CH_N];
    logic [PROD_W-1:0] num_s2_next [CH_N];
    mbo_side_t        side_s2_reg;
    logic [7:0]       pix_s3_next [CH_N];
    mbo_out_t         out_reg;

    assign adv[STAGES-1] = !vld_reg[STAGES-1] || out_ready;
    for (genvar k = 0; k < STAGES - 1; k++) begin : g_adv
        assign adv[k] = !vld_reg[k] || adv[k+1];
    end
    assign in_ready = adv[0];

    always_comb begin
        logic [PROD_W-1:0] x;
        logic [15:0]       y;
        logic [15:0]       s;
        // Zero effective alpha forces the ratio to zero: base passes unchanged.
        if (in_side.zero) begin
            r_eff = '0;
        end else if (in_q > ONE_Q16) begin
            r_eff = ONE_Q16;
        end else begin
            r_eff = in_q;
        end
        for (int c = 0; c < CH_N; c++) begin
            prod_s1_next[c] = DEN_W'(r_eff) * DEN_W'(8'd255 - in_side.top[c]);
            num_s2_next[c]  = PROD_W'(side_s1_reg.base[c]) * PROD_W'(MIX_FULL - prod_s1_reg[c]);
            // round, drop 16 fraction bits, then divide by 255 exactly
            x = num_s2_reg[c] + MIX_HALF;
            y = x[PROD_W-1:16];
            s = y + 16'd1 + (y >> 8);
            pix_s3_next[c] = s[15:8];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < STAGES; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else begin
            if (adv[0]) vld_reg[0] <= in_valid;
            for (int k = 1; k < STAGES; k++) begin
                if (adv[k]) vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            prod_s1_reg <= prod_s1_next;
            side_s1_reg <= in_side;
        end
        if (adv[1]) begin
            num_s2_reg  <= num_s2_next;
            side_s2_reg <= side_s1_reg;
        end
        if (adv[2]) begin
            out_reg.out_blue  <= pix_s3_next[0];
            out_reg.out_green <= pix_s3_next[1];
            out_reg.out_red   <= pix_s3_next[2];
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign out_data  = out_reg;

    a_zero_keeps_base: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[1] && side_s2_reg.zero |->
            num_s2_reg[0] == PROD_W'(side_s2_reg.base[0]) * PROD_W'(MIX_FULL) &&
            num_s2_reg[1] == PROD_W'(side_s2_reg.base[1]) * PROD_W'(MIX_FULL) &&
            num_s2_reg[2] == PROD_W'(side_s2_reg.base[2]) * PROD_W'(MIX_FULL))
        else $error("zero alpha word does not pass base through");

endmodule

`default_nettype wire
